/* sv/mzvrt_pkg.sv */
// Shared types and constants for the multi-zone valve run timer.
// No dependencies; every other file of the block but mzvrt_ram imports it.
package mzvrt_pkg;

  localparam int unsigned OP_W      = 2;
  localparam int unsigned ZONE_W    = 5;
  localparam int unsigned MIN_W     = 8;
  localparam int unsigned SCHED_W   = 8;
  localparam int unsigned MASK_W    = 16;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned MSPM_W    = 16;
  localparam int unsigned PROD_W    = MIN_W + MSPM_W;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 8;

  localparam logic [MSPM_W-1:0] MS_PER_MINUTE = 16'd60000;

  localparam logic [ZONE_W-1:0] ZONE_COUNT_RST  = 5'd8;
  localparam logic [MIN_W-1:0]  MAX_MINUTES_RST = 8'd255;
  localparam logic [ZONE_W-1:0] ZONE_FIRST      = 5'd1;

  typedef enum logic [OP_W-1:0] {
    OP_START    = 2'd0,
    OP_STOP_ALL = 2'd1,
    OP_TICK     = 2'd2,
    OP_NONE     = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ZONE_COUNT  = 2'd0,
    CFG_MAX_MINUTES = 2'd1
  } cfg_idx_e;

endpackage

/* sv/mzvrt_if.sv */
// Valid/ready channel interfaces for the valve run timer: input item,
// result item and configuration write. Depends on mzvrt_pkg.
interface mzvrt_in_if;
  import mzvrt_pkg::*;
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [ZONE_W-1:0]  zone;
  logic [MIN_W-1:0]   minutes;
  logic               manual;
  logic [SCHED_W-1:0] schedule_id;

  modport source (output valid, op, zone, minutes, manual, schedule_id, input ready);
  modport sink   (input valid, op, zone, minutes, manual, schedule_id, output ready);
endinterface

interface mzvrt_out_if;
  import mzvrt_pkg::*;
  logic              valid;
  logic              ready;
  logic              accepted;
  logic [MASK_W-1:0] valve_mask;
  logic [MASK_W-1:0] stopped_mask;
  logic [ZONE_W-1:0] active_zone;

  modport source (output valid, accepted, valve_mask, stopped_mask, active_zone, input ready);
  modport sink   (input valid, accepted, valve_mask, stopped_mask, active_zone, output ready);
endinterface

interface mzvrt_cfg_if;
  import mzvrt_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* sv/mzvrt_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mzvrt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/mzvrt_end_calc.sv */
// End-time calculator: clamp the run time, scale to milliseconds, add to now.
// Two register stages; depends on mzvrt_pkg.
module mzvrt_end_calc (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [mzvrt_pkg::MIN_W-1:0]  minutes_i,
  input  logic [mzvrt_pkg::MIN_W-1:0]  max_minutes_i,
  input  logic [mzvrt_pkg::TIME_W-1:0] now_i,
  output logic                         done_o,
  output logic [mzvrt_pkg::TIME_W-1:0] end_time_o
);
  import mzvrt_pkg::*;

  logic [MIN_W-1:0]  clamped;
  logic [PROD_W-1:0] prod_d, prod_q;
  logic [TIME_W-1:0] end_d, end_q;
  logic              v1_q, v2_q;

  assign clamped = (minutes_i > max_minutes_i) ? max_minutes_i : minutes_i;
  assign prod_d  = PROD_W'(clamped) * PROD_W'(MS_PER_MINUTE);
  assign end_d   = now_i + TIME_W'(prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    end_q  <= end_d;
  end

  assign done_o     = v2_q;
  assign end_time_o = end_q;

endmodule

/* sv/multi_zone_valve_run_timer_core.sv */
// Valve run timer for up to MAX_ZONE_COUNT zones. One item is in work at a time and every
// item yields one result. A stop-all, unused op or rejected start goes straight to the
// result state, a valid start passes through the two stages of the end-time unit, then
// the end-time memory write, and a tick through the scan that reads one end-time entry
// per cycle from the single-read-port memory and compares it once its registered read data arrives.
// The result register frees the input while a result waits.
// Depends on mzvrt_pkg, mzvrt_if, mzvrt_ram and mzvrt_end_calc.
module multi_zone_valve_run_timer_core #(
  parameter int unsigned MAX_ZONE_COUNT = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mzvrt_cfg_if.sink   cfg_i,
  mzvrt_in_if.sink    in_i,
  mzvrt_out_if.source out_o
);
  import mzvrt_pkg::*;

  localparam int unsigned IdxW  = (MAX_ZONE_COUNT > 1) ? $clog2(MAX_ZONE_COUNT) : 1;
  localparam int unsigned CntW  = $clog2(MAX_ZONE_COUNT + 1);
  localparam int unsigned EntW  = SCHED_W + TIME_W;
  localparam logic [ZONE_W-1:0] MaxZone = ZONE_W'(MAX_ZONE_COUNT);
  localparam logic [MASK_W:0] HostMaskW =
    ((MASK_W + 1)'(1) << MAX_ZONE_COUNT) - (MASK_W + 1)'(1);
  localparam logic [MASK_W-1:0] HostMask = HostMaskW[MASK_W-1:0];

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_SCAN,
    S_DONE
  } state_e;

  state_e            state_q;
  logic [ZONE_W-1:0] zone_count_q;
  logic [MIN_W-1:0]  max_min_q;
  logic [TIME_W-1:0] ms_q;
  logic [MASK_W-1:0] active_q, manual_q, stopped_q;
  logic              accepted_q;
  logic [IdxW-1:0]   idx_q, cmp_idx_q;
  logic              manual_in_q;
  logic [SCHED_W-1:0] sched_q;
  logic [CntW-1:0]   scan_q;
  logic              cmp_v_q;

  logic              out_valid_q, out_acc_q;
  logic [MASK_W-1:0] out_valve_q, out_stop_q;
  logic [ZONE_W-1:0] out_zone_q;

  logic [ZONE_W-1:0] live_n, zone_m1, lowest;
  logic [MASK_W-1:0] live_mask, live_active;
  logic              in_fire, start_ok, scan_issue, calc_start, calc_done, out_free;
  logic [TIME_W-1:0] calc_end;
  logic [EntW-1:0]   rd_data;

  assign live_n = (zone_count_q > MaxZone) ? MaxZone : zone_count_q;

  always_comb begin
    for (int i = 0; i < MASK_W; i++) begin
      live_mask[i] = (ZONE_W'(i) < live_n);
    end
  end

  assign live_active = active_q & live_mask;

  always_comb begin
    lowest = '0;
    for (int i = MASK_W - 1; i >= 0; i--) begin
      if (live_active[i]) begin
        lowest = ZONE_W'(i + 1);
      end
    end
  end

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign zone_m1    = in_i.zone - ZONE_FIRST;
  assign start_ok   = (in_i.zone != '0) && (in_i.zone <= live_n);
  assign calc_start = in_fire && (op_e'(in_i.op) == OP_START) && start_ok;
  assign scan_issue = (state_q == S_SCAN) && (ZONE_W'(scan_q) < live_n);
  assign out_free   = !out_valid_q || out_o.ready;

  mzvrt_end_calc u_end_calc (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (calc_start),
    .minutes_i     (in_i.minutes),
    .max_minutes_i (max_min_q),
    .now_i         (ms_q),
    .done_o        (calc_done),
    .end_time_o    (calc_end)
  );

  mzvrt_ram #(
    .WIDTH (EntW),
    .DEPTH (MAX_ZONE_COUNT)
  ) u_zone_ram (
    .clk_i   (clk_i),
    .we_i    ((state_q == S_CALC) && calc_done),
    .waddr_i (idx_q),
    .wdata_i ({sched_q, calc_end}),
    .re_i    (scan_issue),
    .raddr_i (scan_q[IdxW-1:0]),
    .rdata_o (rd_data)
  );

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_count_q <= ZONE_COUNT_RST;
      max_min_q    <= MAX_MINUTES_RST;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_ZONE_COUNT:  zone_count_q <= cfg_i.data[ZONE_W-1:0];
        CFG_MAX_MINUTES: max_min_q    <= cfg_i.data[MIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ms_q        <= '0;
      active_q    <= '0;
      manual_q    <= '0;
      stopped_q   <= '0;
      accepted_q  <= 1'b1;
      scan_q      <= '0;
      cmp_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            accepted_q  <= 1'b1;
            stopped_q   <= '0;
            idx_q       <= zone_m1[IdxW-1:0];
            manual_in_q <= in_i.manual;
            sched_q     <= in_i.schedule_id;
            case (op_e'(in_i.op))
              OP_START: begin
                accepted_q <= start_ok;
                state_q    <= start_ok ? S_CALC : S_DONE;
              end
              OP_STOP_ALL: begin
                stopped_q <= live_active;
                active_q  <= active_q & ~live_mask;
                manual_q  <= manual_q & ~live_mask;
                state_q   <= S_DONE;
              end
              OP_TICK: begin
                ms_q    <= ms_q + TIME_W'(1);
                scan_q  <= '0;
                cmp_v_q <= 1'b0;
                state_q <= S_SCAN;
              end
              default: state_q <= S_DONE;
            endcase
          end
        end
        S_CALC: begin
          if (calc_done) begin
            active_q[idx_q] <= 1'b1;
            manual_q[idx_q] <= manual_in_q;
            state_q         <= S_DONE;
          end
        end
        S_SCAN: begin
          cmp_v_q   <= scan_issue;
          cmp_idx_q <= scan_q[IdxW-1:0];
          if (scan_issue) begin
            scan_q <= scan_q + CntW'(1);
          end
          if (cmp_v_q && active_q[cmp_idx_q] && (ms_q > rd_data[TIME_W-1:0])) begin
            active_q[cmp_idx_q]  <= 1'b0;
            manual_q[cmp_idx_q]  <= 1'b0;
            stopped_q[cmp_idx_q] <= 1'b1;
          end
          if (!scan_issue && !cmp_v_q) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_acc_q   <= accepted_q;
            out_valve_q <= active_q;
            out_stop_q  <= stopped_q;
            out_zone_q  <= lowest;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.accepted     = out_acc_q;
  assign out_o.valve_mask   = out_valve_q;
  assign out_o.stopped_mask = out_stop_q;
  assign out_o.active_zone  = out_zone_q;

  a_no_scan_when_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !cmp_v_q)
    else $error("compare pending while input ready");

  a_host_zones_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active_q & ~HostMask) == '0)
    else $error("zone active beyond hosted count");

  a_stopped_inactive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |-> ((stopped_q & active_q) == '0))
    else $error("stopped zone still active");

  a_ms_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(ms_q) |-> (ms_q == $past(ms_q) + TIME_W'(1)))
    else $error("millisecond counter moved by other than one");

endmodule

/* tb/mzvrt_checker.sv */
// Result checker for the multi-zone valve run timer: watches the config, item and result
// channels, predicts every result and compares it. Depends on mzvrt_pkg and mzvrt_if.
module mzvrt_checker #(
  parameter int unsigned ZONE_SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mzvrt_cfg_if        cfg_mon_i,
  mzvrt_in_if         in_mon_i,
  mzvrt_out_if        out_mon_i,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o,
  output int unsigned result_cnt_o,
  output int unsigned expired_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import mzvrt_pkg::*;

  typedef struct packed {
    logic              accepted;
    logic [MASK_W-1:0] valve_mask;
    logic [MASK_W-1:0] stopped_mask;
    logic [ZONE_W-1:0] active_zone;
  } valve_result_t;

  logic [TIME_W-1:0]  ms_now;
  logic [TIME_W-1:0]  end_time [ZONE_SLOTS];
  logic [SCHED_W-1:0] sched_id [ZONE_SLOTS];
  logic [MASK_W-1:0]  zone_on;
  logic [MASK_W-1:0]  zone_manual;
  logic [ZONE_W-1:0]  zone_cnt;
  logic [MIN_W-1:0]   max_min;
  valve_result_t      valve_want_q [$];

  function automatic valve_result_t step_valves(op_e op, logic [ZONE_W-1:0] zone,
                                                logic [MIN_W-1:0] minutes, logic manual,
                                                logic [SCHED_W-1:0] sched);
    valve_result_t    r;
    int unsigned      span;
    logic [3:0]       idx;
    logic [MIN_W-1:0] run_min;
    span = (zone_cnt > ZONE_SLOTS) ? ZONE_SLOTS : zone_cnt;
    r.accepted = 1'b1;
    r.stopped_mask = '0;
    case (op)
      OP_START: begin
        if (zone < ZONE_FIRST || zone > span) begin
          r.accepted = 1'b0;
        end else begin
          idx = 4'(zone - ZONE_FIRST);
          run_min = (minutes > max_min) ? max_min : minutes;
          end_time[idx] = ms_now + TIME_W'(run_min) * TIME_W'(MS_PER_MINUTE);
          sched_id[idx] = sched;
          zone_manual[idx] = manual;
          zone_on[idx] = 1'b1;
        end
      end
      OP_STOP_ALL, OP_TICK: begin
        if (op == OP_TICK) ms_now = ms_now + 1;
        for (int i = 0; i < int'(span); i++) begin
          if (zone_on[i] && (op == OP_STOP_ALL || ms_now > end_time[i])) begin
            zone_on[i] = 1'b0;
            zone_manual[i] = 1'b0;
            r.stopped_mask[i] = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.valve_mask = zone_on;
    r.active_zone = '0;
    for (int i = int'(span) - 1; i >= 0; i--) begin
      if (zone_on[i]) r.active_zone = ZONE_W'(i + 1);
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    valve_result_t got;
    valve_result_t want;
    if (!rst_ni) begin
      ms_now = '0;
      zone_on = '0;
      zone_manual = '0;
      zone_cnt = ZONE_COUNT_RST;
      max_min = MAX_MINUTES_RST;
      for (int i = 0; i < int'(ZONE_SLOTS); i++) begin
        end_time[i] = '0;
        sched_id[i] = '0;
      end
      valve_want_q.delete();
      fail_cnt_o = 0;
      pending_o = 0;
      result_cnt_o = 0;
      expired_cnt_o = 0;
    end else begin
      if (cfg_mon_i.valid && cfg_mon_i.ready) begin
        case (cfg_idx_e'(cfg_mon_i.index))
          CFG_ZONE_COUNT:  zone_cnt = cfg_mon_i.data[ZONE_W-1:0];
          CFG_MAX_MINUTES: max_min = cfg_mon_i.data[MIN_W-1:0];
          default: ;
        endcase
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        want = step_valves(op_e'(in_mon_i.op), in_mon_i.zone, in_mon_i.minutes,
                           in_mon_i.manual, in_mon_i.schedule_id);
        if (op_e'(in_mon_i.op) == OP_TICK) expired_cnt_o += $countones(want.stopped_mask);
        valve_want_q.push_back(want);
      end
      if (out_mon_i.valid && out_mon_i.ready) begin
        got.accepted = out_mon_i.accepted;
        got.valve_mask = out_mon_i.valve_mask;
        got.stopped_mask = out_mon_i.stopped_mask;
        got.active_zone = out_mon_i.active_zone;
        result_cnt_o++;
        if (valve_want_q.size() == 0) begin
          fail_cnt_o++;
          if (fail_cnt_o <= 10)
            $display("%0t: result %0d arrived with nothing expected: acc=%0b valves=%04h",
                     $realtime, result_cnt_o, got.accepted, got.valve_mask);
        end else begin
          want = valve_want_q.pop_front();
          if (got.accepted !== want.accepted || got.valve_mask !== want.valve_mask ||
              got.stopped_mask !== want.stopped_mask ||
              got.active_zone !== want.active_zone) begin
            fail_cnt_o++;
            if (fail_cnt_o <= 10)
              $display({"%0t: result %0d mismatch: got acc=%0b valves=%04h stopped=%04h ",
                        "lowest=%0d, want acc=%0b valves=%04h stopped=%04h lowest=%0d"},
                       $realtime, result_cnt_o, got.accepted, got.valve_mask,
                       got.stopped_mask, got.active_zone, want.accepted, want.valve_mask,
                       want.stopped_mask, want.active_zone);
          end
        end
      end
      pending_o = valve_want_q.size();
    end
  end

endmodule

/* tb/tb_multi_zone_valve_run_timer_core.sv */
// Stimulus top for the multi-zone valve run timer: directed and random items, config phases,
// random idling and a closing timer run. Needs mzvrt_pkg, mzvrt_if, mzvrt_checker and the core.
module tb_multi_zone_valve_run_timer_core;
  timeunit 1ns;
  timeprecision 1ps;
  import mzvrt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned LONG_TICKS  = 40;

  logic        clk;
  logic        rst_n;
  logic        idle_en;
  logic        hold_req;
  int unsigned cycle_cnt;
  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned result_cnt;
  int unsigned expired_cnt;
  int unsigned op_seen [4];
  int unsigned reg_writes;
  int unsigned cur_zones;

  mzvrt_cfg_if cfg_ch ();
  mzvrt_in_if  in_ch ();
  mzvrt_out_if out_ch ();

  multi_zone_valve_run_timer_core #(
    .MAX_ZONE_COUNT(16)
  ) i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_i (cfg_ch.sink),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  mzvrt_checker #(
    .ZONE_SLOTS(16)
  ) i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_mon_i    (cfg_ch),
    .in_mon_i     (in_ch),
    .out_mon_i    (out_ch),
    .fail_cnt_o   (fail_cnt),
    .pending_o    (pending),
    .result_cnt_o (result_cnt),
    .expired_cnt_o(expired_cnt)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results still expected", cycle_cnt, pending);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    out_ch.ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(0, 11)) @(negedge clk);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  task automatic push_item(input op_e op, input logic [ZONE_W-1:0] zone,
                           input logic [MIN_W-1:0] minutes, input logic manual,
                           input logic [SCHED_W-1:0] sched);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_ch.op = op;
    in_ch.zone = zone;
    in_ch.minutes = minutes;
    in_ch.manual = manual;
    in_ch.schedule_id = sched;
    in_ch.valid = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    op_seen[op]++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid = 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int unsigned value);
    wait_drained();
    cfg_ch.index = idx;
    cfg_ch.data = CFG_DAT_W'(value);
    cfg_ch.valid = 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    reg_writes++;
    if (idx == CFG_ZONE_COUNT) cur_zones = value;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic run_random(input int unsigned n_items);
    int unsigned        pick;
    int unsigned        span;
    op_e                op;
    logic [ZONE_W-1:0]  zone;
    logic [MIN_W-1:0]   minutes;
    span = (cur_zones > 16) ? 16 : cur_zones;
    repeat (n_items) begin
      pick = $urandom_range(0, 99);
      op = (pick < 45) ? OP_START : (pick < 89) ? OP_TICK : (pick < 96) ? OP_STOP_ALL : OP_NONE;
      if (span > 0 && $urandom_range(0, 9) < 7) zone = ZONE_W'($urandom_range(1, span));
      else zone = ZONE_W'($urandom_range(0, 31));
      if ($urandom_range(0, 2) == 0) minutes = '0;
      else minutes = MIN_W'($urandom_range(0, 255));
      push_item(op, zone, minutes, 1'($urandom), SCHED_W'($urandom));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    idle_en = 1'b1;
    hold_req = 1'b0;
    reg_writes = 0;
    cur_zones = ZONE_COUNT_RST;
    foreach (op_seen[i]) op_seen[i] = 0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_NONE;
    in_ch.zone = '0;
    in_ch.minutes = '0;
    in_ch.manual = 1'b0;
    in_ch.schedule_id = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_ZONE_COUNT;
    cfg_ch.data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    push_item(OP_NONE, 5'd31, 8'd255, 1'b1, 8'd255);
    push_item(OP_START, 5'd0, 8'd10, 1'b0, 8'd1);
    push_item(OP_START, 5'd9, 8'd10, 1'b0, 8'd2);
    push_item(OP_START, 5'd1, 8'd0, 1'b1, 8'd255);
    push_item(OP_START, 5'd8, 8'd255, 1'b0, 8'd0);
    push_item(OP_START, 5'd16, 8'd1, 1'b1, 8'd3);
    push_item(OP_TICK, 5'd0, 8'd0, 1'b0, 8'd0);
    push_item(OP_START, 5'd3, 8'd0, 1'b0, 8'd4);
    push_item(OP_START, 5'd3, 8'd255, 1'b1, 8'd5);
    push_item(OP_TICK, 5'd31, 8'd255, 1'b1, 8'd255);
    push_item(OP_STOP_ALL, 5'd0, 8'd0, 1'b0, 8'd0);
    push_item(OP_STOP_ALL, 5'd31, 8'd255, 1'b1, 8'd255);
    push_item(OP_TICK, 5'd0, 8'd0, 1'b0, 8'd0);
    write_reg(CFG_ZONE_COUNT, 0);
    push_item(OP_START, 5'd1, 8'd5, 1'b0, 8'd6);
    push_item(OP_STOP_ALL, 5'd0, 8'd0, 1'b0, 8'd0);
    write_reg(CFG_ZONE_COUNT, 31);
    push_item(OP_START, 5'd16, 8'd0, 1'b1, 8'd7);
    push_item(OP_START, 5'd17, 8'd0, 1'b0, 8'd8);
    push_item(OP_START, 5'd2, 8'd200, 1'b0, 8'd9);
    write_reg(CFG_ZONE_COUNT, 4);
    push_item(OP_STOP_ALL, 5'd0, 8'd0, 1'b0, 8'd0);
    push_item(OP_TICK, 5'd0, 8'd0, 1'b0, 8'd0);
    write_reg(CFG_ZONE_COUNT, 16);
    push_item(OP_TICK, 5'd0, 8'd0, 1'b0, 8'd0);
    push_item(OP_STOP_ALL, 5'd0, 8'd0, 1'b0, 8'd0);

    write_reg(CFG_MAX_MINUTES, 255);
    hold_req = 1'b1;
    run_random(300);
    write_reg(CFG_MAX_MINUTES, 0);
    run_random(300);
    write_reg(CFG_ZONE_COUNT, 1);
    write_reg(CFG_MAX_MINUTES, 255);
    run_random(300);
    write_reg(CFG_ZONE_COUNT, 5);
    write_reg(CFG_MAX_MINUTES, 37);
    run_random(300);
    write_reg(CFG_ZONE_COUNT, 20);
    write_reg(CFG_MAX_MINUTES, 0);
    run_random(300);
    write_reg(CFG_ZONE_COUNT, 12);
    write_reg(CFG_MAX_MINUTES, 200);
    run_random(300);

    // run two zones with the run time clamped to zero, one of them restarted
    wait_drained();
    idle_en = 1'b0;
    write_reg(CFG_ZONE_COUNT, 2);
    write_reg(CFG_MAX_MINUTES, 0);
    push_item(OP_STOP_ALL, 5'd0, 8'd0, 1'b0, 8'd0);
    push_item(OP_START, 5'd1, 8'd1, 1'b0, 8'd11);
    repeat (5) push_item(OP_TICK, 5'd0, 8'd0, 1'b0, 8'd0);
    push_item(OP_START, 5'd2, 8'd255, 1'b1, 8'd12);
    repeat (5) push_item(OP_TICK, 5'd0, 8'd0, 1'b0, 8'd0);
    push_item(OP_START, 5'd2, 8'd9, 1'b0, 8'd13);
    repeat (LONG_TICKS - 10) begin
      push_item(OP_TICK, ZONE_W'($urandom), MIN_W'($urandom), 1'($urandom),
                SCHED_W'($urandom));
    end

    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(posedge clk);
    $display("items: %0d starts, %0d stop-all, %0d ticks, %0d unused op; %0d register writes",
             op_seen[OP_START], op_seen[OP_STOP_ALL], op_seen[OP_TICK], op_seen[OP_NONE],
             reg_writes);
    $display("results checked: %0d, zones expired by ticks: %0d, mismatches: %0d",
             result_cnt, expired_cnt, fail_cnt);
    if (fail_cnt == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* multi_zone_valve_run_timer_core.f */
sv/mzvrt_pkg.sv
sv/mzvrt_if.sv
sv/mzvrt_ram.sv
sv/mzvrt_end_calc.sv
sv/multi_zone_valve_run_timer_core.sv
tb/mzvrt_checker.sv
tb/tb_multi_zone_valve_run_timer_core.sv
